// ===== rtl/rgb_led_chain_frame_encoder_macros.svh =====
// Assertion macros shared by the RGB LED chain encoder RTL.
// Simulation builds get concurrent checks; synthesis builds get nothing.
`ifndef RGB_LED_CHAIN_FRAME_ENCODER_MACROS_SVH
`define RGB_LED_CHAIN_FRAME_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define RLCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlce check failed");
// antecedent implies consequent in the next cycle
`define RLCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlce check failed");
`else
`define RLCE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RLCE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/rlce_pkg.sv =====
// Shared types, codes and tables for the RGB LED chain frame encoder.
// No dependencies.
`default_nettype none
package rlce_pkg;

  localparam int unsigned LED_COUNT_DEF = 32;
  localparam int unsigned BITS_PER_LED  = 24;
  localparam int unsigned BIT_POS_W     = 5;
  localparam int unsigned DUTY_W        = 9;
  localparam int unsigned CFG_IDX_W     = 3;

  localparam logic [DUTY_W-1:0] DUTY_ZERO_RST    = 9'd60;
  localparam logic [DUTY_W-1:0] DUTY_ONE_RST     = 9'd120;
  localparam logic              BLINK_EN_RST     = 1'b1;
  localparam logic [7:0]        LIT_TICKS_RST    = 8'd10;
  localparam logic [7:0]        BLINK_PERIOD_RST = 8'd100;

  typedef enum logic [2:0] {
    FUNC_SET_COLOR = 3'd0,
    FUNC_REFRESH   = 3'd1,
    FUNC_BUILD     = 3'd2,
    FUNC_TICK      = 3'd3,
    FUNC_SLOT      = 3'd4
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUTY_ZERO    = 3'd0,
    REG_DUTY_ONE     = 3'd1,
    REG_BLINK_EN     = 3'd2,
    REG_LIT_TICKS    = 3'd3,
    REG_BLINK_PERIOD = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STARTED_NONE = 2'd0,
    STARTED_LIT  = 2'd1,
    STARTED_DARK = 2'd2
  } started_e;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_zero;
    logic [DUTY_W-1:0] duty_one;
    logic              blink_en;
    logic [7:0]        lit_ticks;
    logic [7:0]        blink_period;
  } cfg_t;

  // gamma 2.2 correction, indexed by raw 8-bit brightness
  localparam logic [7:0] GAMMA_LUT [0:255] = '{
    8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,
    8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,
    8'd3,8'd3,8'd3,8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,8'd5,8'd6,8'd6,8'd6,
    8'd6,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd10,8'd10,8'd11,8'd11,8'd11,
    8'd12,8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd15,8'd15,8'd16,8'd16,8'd17,8'd17,
    8'd18,8'd18,8'd19,8'd19,8'd20,8'd20,8'd21,8'd22,8'd22,8'd23,8'd23,8'd24,8'd25,
    8'd25,8'd26,8'd26,8'd27,8'd28,8'd28,8'd29,8'd30,8'd30,8'd31,8'd32,8'd33,8'd33,
    8'd34,8'd35,8'd35,8'd36,8'd37,8'd38,8'd39,8'd39,8'd40,8'd41,8'd42,8'd43,8'd43,
    8'd44,8'd45,8'd46,8'd47,8'd48,8'd49,8'd49,8'd50,8'd51,8'd52,8'd53,8'd54,8'd55,
    8'd56,8'd57,8'd58,8'd59,8'd60,8'd61,8'd62,8'd63,8'd64,8'd65,8'd66,8'd67,8'd68,
    8'd69,8'd70,8'd71,8'd73,8'd74,8'd75,8'd76,8'd77,8'd78,8'd79,8'd81,8'd82,8'd83,
    8'd84,8'd85,8'd87,8'd88,8'd89,8'd90,8'd91,8'd93,8'd94,8'd95,8'd97,8'd98,8'd99,
    8'd100,8'd102,8'd103,8'd105,8'd106,8'd107,8'd109,8'd110,8'd111,8'd113,8'd114,
    8'd116,8'd117,8'd119,8'd120,8'd121,8'd123,8'd124,8'd126,8'd127,8'd129,8'd130,
    8'd132,8'd133,8'd135,8'd137,8'd138,8'd140,8'd141,8'd143,8'd145,8'd146,8'd148,
    8'd149,8'd151,8'd153,8'd154,8'd156,8'd158,8'd159,8'd161,8'd163,8'd165,8'd166,
    8'd168,8'd170,8'd172,8'd173,8'd175,8'd177,8'd179,8'd181,8'd182,8'd184,8'd186,
    8'd188,8'd190,8'd192,8'd194,8'd196,8'd197,8'd199,8'd201,8'd203,8'd205,8'd207,
    8'd209,8'd211,8'd213,8'd215,8'd217,8'd219,8'd221,8'd223,8'd225,8'd227,8'd229,
    8'd231,8'd234,8'd236,8'd238,8'd240,8'd242,8'd244,8'd246,8'd248,8'd251,8'd253,
    8'd255
  };

endpackage
`default_nettype wire

// ===== rtl/rgb_led_chain_frame_encoder.sv =====
// RGB LED chain frame encoder, top level: config registers plus sequencer.
// Each item passes the execute state before its done_o strobe; a data slot
// also passes slot-wait, and a frame build with a refresh pending walks a
// read and a write state per LED, writing only dirty LEDs. One item at a
// time; busy stays high meanwhile. Results cannot be stalled by the receiver.
// Async active-low reset: frame and color stores read as zero, all LEDs dirty.
`default_nettype none
module rgb_led_chain_frame_encoder
  import rlce_pkg::*;
#(
  parameter int unsigned LED_COUNT = LED_COUNT_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DUTY_W-1:0]    cfg_wdata_i,
  // item command
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [2:0]           func_i,
  input  wire logic [7:0]           led_index_i,
  input  wire logic [7:0]           red_i,
  input  wire logic [7:0]           green_i,
  input  wire logic [7:0]           blue_i,
  // result, valid for the single cycle done_o is high
  output logic                      done_o,
  output logic                      status_o,
  output logic [DUTY_W-1:0]         duty_o,
  output logic                      last_slot_o,
  output logic                      sending_o,
  output logic [1:0]                started_o
);

  // Config registers. The user must write them only while idle, so the
  // sequencer sees stable values for the whole item; the block does not enforce it.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_zero    <= DUTY_ZERO_RST;
      cfg_q.duty_one     <= DUTY_ONE_RST;
      cfg_q.blink_en     <= BLINK_EN_RST;
      cfg_q.lit_ticks    <= LIT_TICKS_RST;
      cfg_q.blink_period <= BLINK_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DUTY_ZERO:    cfg_q.duty_zero    <= cfg_wdata_i;
        REG_DUTY_ONE:     cfg_q.duty_one     <= cfg_wdata_i;
        REG_BLINK_EN:     cfg_q.blink_en     <= cfg_wdata_i[0];
        REG_LIT_TICKS:    cfg_q.lit_ticks    <= cfg_wdata_i[7:0];
        REG_BLINK_PERIOD: cfg_q.blink_period <= cfg_wdata_i[7:0];
        default: begin
          // unmapped index: write is dropped
        end
      endcase
    end
  end

  // Sequencer owns both stores, the dirty walk, blink timer and the
  // slot pointer (LED number plus bit position, MSB first).
  rlce_ctrl #(
    .LED_COUNT(LED_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .start      (start),
    .busy       (busy),
    .func_i     (func_i),
    .led_index_i(led_index_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .duty_o     (duty_o),
    .last_slot_o(last_slot_o),
    .sending_o  (sending_o),
    .started_o  (started_o)
  );

endmodule
`default_nettype wire

// ===== rtl/rlce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rlce_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/rlce_ctrl.sv =====
// Sequencer and datapath of the LED chain encoder: color/frame RAMs,
// dirty walk, blink timer and slot encoder. Uses rlce_pkg, rlce_ram.
`default_nettype none
`include "rgb_led_chain_frame_encoder_macros.svh"
module rlce_ctrl
  import rlce_pkg::*;
#(
  parameter int unsigned LED_COUNT = LED_COUNT_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        func_i,
  input  wire logic [7:0]        led_index_i,
  input  wire logic [7:0]        red_i,
  input  wire logic [7:0]        green_i,
  input  wire logic [7:0]        blue_i,
  output logic                   done_o,
  output logic                   status_o,
  output logic [DUTY_W-1:0]      duty_o,
  output logic                   last_slot_o,
  output logic                   sending_o,
  output logic [1:0]             started_o
);

  localparam int unsigned AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned PW = $clog2(LED_COUNT + 1);
  localparam logic [BIT_POS_W-1:0] TOP_BIT = BIT_POS_W'(BITS_PER_LED - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BUILD_RD,
    ST_BUILD_WR,
    ST_SLOT_WAIT
  } state_e;

  state_e                 state_q;
  func_e                  func_q;
  logic [7:0]             idx_q, red_q, green_q, blue_q;
  logic                   refresh_q;
  logic [7:0]             blink_cnt_q;
  logic                   send_pend_q, lit_phase_q;
  logic                   active_q, dark_q;
  logic [PW-1:0]          led_ptr_q;
  logic [BIT_POS_W-1:0]   bit_pos_q;
  logic [AW-1:0]          build_idx_q;
  logic [LED_COUNT-1:0]   dirty_q, cvalid_q, fvalid_q;
  logic                   done_q, status_q, last_q;
  logic [DUTY_W-1:0]      duty_q;
  started_e               started_q;

  // blink tick, next-state values
  logic [7:0] blink_top, blink_cnt_d;
  logic       send_pend_d, lit_phase_d, xfer_go, xfer_dark;

  always_comb begin
    blink_top   = (cfg_i.blink_period == 8'd0) ? 8'd0 : cfg_i.blink_period - 8'd1;
    send_pend_d = send_pend_q;
    lit_phase_d = lit_phase_q;
    if (blink_cnt_q < blink_top) begin
      blink_cnt_d = blink_cnt_q + 8'd1;
    end else begin
      blink_cnt_d = 8'd0;
      send_pend_d = 1'b1;
      lit_phase_d = 1'b1;
    end
    if (lit_phase_d && (blink_cnt_d >= cfg_i.lit_ticks)) begin
      send_pend_d = 1'b1;
      lit_phase_d = 1'b0;
    end
    xfer_go   = 1'b0;
    xfer_dark = 1'b0;
    if (cfg_i.blink_en) begin
      if (send_pend_d) begin
        send_pend_d = 1'b0;
        xfer_go     = 1'b1;
        xfer_dark   = !lit_phase_d;
      end
    end else begin
      xfer_go = 1'b1;
    end
  end

  // color store: written by set color, read by the build walk
  logic                       idx_ok;
  logic                       c_we;
  logic [BITS_PER_LED-1:0]    c_wdata, c_rdata;
  // frame store: written by the build walk, read by slot requests
  logic                       f_we;
  logic [BITS_PER_LED-1:0]    f_wdata, f_rdata, frame_word;
  logic                       slot_bit;

  assign idx_ok  = idx_q < 8'(LED_COUNT);
  assign c_we    = (state_q == ST_EXEC) && (func_q == FUNC_SET_COLOR) && idx_ok;
  assign c_wdata = {GAMMA_LUT[green_q], GAMMA_LUT[red_q], GAMMA_LUT[blue_q]};
  assign f_we    = (state_q == ST_BUILD_WR) && dirty_q[build_idx_q];
  assign f_wdata = cvalid_q[build_idx_q] ? c_rdata : '0;

  assign frame_word = fvalid_q[led_ptr_q[AW-1:0]] ? f_rdata : '0;
  assign slot_bit   = !dark_q && frame_word[TOP_BIT - bit_pos_q];

  rlce_ram #(
    .WIDTH(BITS_PER_LED),
    .DEPTH(LED_COUNT)
  ) u_color_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(idx_q[AW-1:0]),
    .wdata_i(c_wdata),
    .raddr_i(build_idx_q),
    .rdata_o(c_rdata)
  );

  rlce_ram #(
    .WIDTH(BITS_PER_LED),
    .DEPTH(LED_COUNT)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .waddr_i(build_idx_q),
    .wdata_i(f_wdata),
    .raddr_i(led_ptr_q[AW-1:0]),
    .rdata_o(f_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      func_q      <= FUNC_SET_COLOR;
      idx_q       <= '0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
      refresh_q   <= 1'b1;
      blink_cnt_q <= '0;
      send_pend_q <= 1'b0;
      lit_phase_q <= 1'b0;
      active_q    <= 1'b0;
      dark_q      <= 1'b0;
      led_ptr_q   <= '0;
      bit_pos_q   <= '0;
      build_idx_q <= '0;
      dirty_q     <= '1;
      cvalid_q    <= '0;
      fvalid_q    <= '0;
      done_q      <= 1'b0;
      status_q    <= 1'b0;
      duty_q      <= '0;
      last_q      <= 1'b0;
      started_q   <= STARTED_NONE;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            func_q  <= func_e'(func_i);
            idx_q   <= led_index_i;
            red_q   <= red_i;
            green_q <= green_i;
            blue_q  <= blue_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          status_q  <= 1'b0;
          duty_q    <= '0;
          last_q    <= 1'b0;
          started_q <= STARTED_NONE;
          done_q    <= 1'b1;
          state_q   <= ST_IDLE;
          unique case (func_q)
            FUNC_SET_COLOR: begin
              if (idx_ok) begin
                dirty_q[idx_q[AW-1:0]]  <= 1'b1;
                cvalid_q[idx_q[AW-1:0]] <= 1'b1;
              end else begin
                status_q <= 1'b1;
              end
            end
            FUNC_REFRESH: begin
              refresh_q <= 1'b1;
            end
            FUNC_BUILD: begin
              if (refresh_q) begin
                refresh_q   <= 1'b0;
                build_idx_q <= '0;
                done_q      <= 1'b0;
                state_q     <= ST_BUILD_RD;
              end
            end
            FUNC_TICK: begin
              blink_cnt_q <= blink_cnt_d;
              send_pend_q <= send_pend_d;
              lit_phase_q <= lit_phase_d;
              if (xfer_go) begin
                active_q  <= 1'b1;
                dark_q    <= xfer_dark;
                led_ptr_q <= '0;
                bit_pos_q <= '0;
                started_q <= xfer_dark ? STARTED_DARK : STARTED_LIT;
              end
            end
            FUNC_SLOT: begin
              if (active_q) begin
                if (led_ptr_q < PW'(LED_COUNT)) begin
                  done_q  <= 1'b0;
                  state_q <= ST_SLOT_WAIT;
                end else begin
                  last_q    <= 1'b1;
                  active_q  <= 1'b0;
                  led_ptr_q <= '0;
                  bit_pos_q <= '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
        ST_BUILD_RD: begin
          state_q <= ST_BUILD_WR;
        end
        ST_BUILD_WR: begin
          if (dirty_q[build_idx_q]) begin
            dirty_q[build_idx_q]  <= 1'b0;
            fvalid_q[build_idx_q] <= 1'b1;
          end
          if (build_idx_q == AW'(LED_COUNT - 1)) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            build_idx_q <= build_idx_q + AW'(1);
            state_q     <= ST_BUILD_RD;
          end
        end
        ST_SLOT_WAIT: begin
          duty_q <= slot_bit ? cfg_i.duty_one : cfg_i.duty_zero;
          if (bit_pos_q == TOP_BIT) begin
            bit_pos_q <= '0;
            led_ptr_q <= led_ptr_q + PW'(1);
          end else begin
            bit_pos_q <= bit_pos_q + BIT_POS_W'(1);
          end
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign duty_o      = duty_q;
  assign last_slot_o = last_q;
  assign sending_o   = active_q;
  assign started_o   = started_q;

  `RLCE_ASSERT_IMPL(a_last_ends_xfer, clk_i, rst_ni, done_q && last_q, !active_q)
  `RLCE_ASSERT_IMPL(a_start_sets_active, clk_i, rst_ni,
                    done_q && (started_q != STARTED_NONE), active_q)
  `RLCE_ASSERT_IMPL(a_duty_only_slot, clk_i, rst_ni,
                    done_q && (duty_q != '0), func_q == FUNC_SLOT)
  `RLCE_ASSERT_IMPL(a_slot_ptr_in_range, clk_i, rst_ni,
                    state_q == ST_SLOT_WAIT, led_ptr_q < PW'(LED_COUNT))
  `RLCE_ASSERT_NEXT(a_build_clears_refresh, clk_i, rst_ni,
                    state_q == ST_BUILD_RD, !refresh_q || (state_q == ST_BUILD_WR))

endmodule
`default_nettype wire
